// ----- src/scfd_pkg.sv -----
package scfd_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_HALT_ON_EMPTY      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_STOP_AXIS0   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_STOP_AXIS1   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_INVERT_AXIS0 = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_INVERT_AXIS1 = 8'd4;

  localparam int unsigned FREE_SLOTS_W = 6;

  // Queue control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  // Queue status back to the sequencer
  typedef struct packed {
    logic full;
    logic empty;
    logic last_slot;
  } queue_status_t;

endpackage

// ----- src/scfd_cmd_if.sv -----
interface scfd_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] command_byte;
  logic       limit_pin0;
  logic       limit_pin1;

  modport source (output valid, output op, output command_byte, output limit_pin0,
                  output limit_pin1, input ready);
  modport sink (input valid, input op, input command_byte, input limit_pin0,
                input limit_pin1, output ready);
endinterface

// ----- src/scfd_res_if.sv -----
interface scfd_res_if;
  logic       valid;
  logic       ready;
  logic       step0;
  logic       dir0;
  logic       enable0_n;
  logic       step1;
  logic       dir1;
  logic       enable1_n;
  logic [5:0] free_slots;
  logic       append_accepted;
  logic       write_release;
  logic       underrun;
  logic       running;

  modport source (output valid, output step0, output dir0, output enable0_n,
                  output step1, output dir1, output enable1_n, output free_slots,
                  output append_accepted, output write_release, output underrun,
                  output running, input ready);
  modport sink (input valid, input step0, input dir0, input enable0_n,
                input step1, input dir1, input enable1_n, input free_slots,
                input append_accepted, input write_release, input underrun,
                input running, output ready);
endinterface

// ----- src/scfd_cfg_if.sv -----
interface scfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic       wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- src/stepper_command_fifo_driver_unit.sv -----
// Two-axis step command queue. Append requests store a command byte in a queue of
// QUEUE_DEPTH bytes; tick requests pop one nibble (low nibble first) and drive both
// motors from it; a restart request resumes ticks after a stall. The block takes one
// request per clock cycle while its result register is free or being drained, and
// registers the result there for the next cycle; a new request is taken while the
// previous result is being taken, so requests can flow back to back. The queue memory
// is read ahead into a head register, so the pop path sees only registered data.
// Configuration is written through its own port, which is always ready, and should
// be written only while the block is idle.
module stepper_command_fifo_driver_unit #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input logic        clk,
  input logic        rst,
  scfd_cmd_if.sink   cmd,
  scfd_res_if.source res,
  scfd_cfg_if.sink   cfg
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH+1);

  // Configuration registers
  logic halt_on_empty;
  logic limit_stop_axis0;
  logic limit_stop_axis1;
  logic limit_invert_axis0;
  logic limit_invert_axis1;

  // Sequencer state
  logic       upper_half;
  logic [1:0] direction_bits;
  logic [1:0] enable_bits_n;
  logic       tick_running;
  logic       upper_half_next;
  logic [1:0] direction_bits_next;
  logic [1:0] enable_bits_n_next;
  logic       tick_running_next;

  // Queue interface
  scfd_pkg::queue_ctrl_t   q_ctrl;
  scfd_pkg::queue_status_t q_status;
  logic [7:0]              q_head;
  logic [CW-1:0]           q_count;
  logic [CW-1:0]           count_after;
  logic [CW+5:0]           count_ext;

  // Per-request results
  logic       accept;
  logic [3:0] nibble;
  logic       freeze0;
  logic       freeze1;
  logic       step0_next;
  logic       step1_next;
  logic       accepted_next;
  logic       release_next;
  logic       underrun_next;
  logic       res_valid;

  assign cfg.ready = 1'b1;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      halt_on_empty      <= 1'b0;
      limit_stop_axis0   <= 1'b0;
      limit_stop_axis1   <= 1'b0;
      limit_invert_axis0 <= 1'b0;
      limit_invert_axis1 <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        scfd_pkg::REG_HALT_ON_EMPTY:      halt_on_empty      <= cfg.wdata;
        scfd_pkg::REG_LIMIT_STOP_AXIS0:   limit_stop_axis0   <= cfg.wdata;
        scfd_pkg::REG_LIMIT_STOP_AXIS1:   limit_stop_axis1   <= cfg.wdata;
        scfd_pkg::REG_LIMIT_INVERT_AXIS0: limit_invert_axis0 <= cfg.wdata;
        scfd_pkg::REG_LIMIT_INVERT_AXIS1: limit_invert_axis1 <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Take a request when the result register is free or being drained
  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign nibble  = upper_half ? q_head[7:4] : q_head[3:0];
  assign freeze0 = (cmd.limit_pin0 ^ limit_invert_axis0) && limit_stop_axis0;
  assign freeze1 = (cmd.limit_pin1 ^ limit_invert_axis1) && limit_stop_axis1;

  // Decode the request and update motor state
  always_comb begin
    upper_half_next     = upper_half;
    direction_bits_next = direction_bits;
    enable_bits_n_next  = enable_bits_n;
    tick_running_next   = tick_running;
    q_ctrl              = '0;
    step0_next          = 1'b0;
    step1_next          = 1'b0;
    accepted_next       = 1'b0;
    release_next        = 1'b0;
    underrun_next       = 1'b0;
    if (accept) begin
      case (cmd.op)
        scfd_pkg::OP_APPEND: begin
          if (!q_status.full) begin
            q_ctrl.push   = 1'b1;
            accepted_next = !q_status.last_slot;
          end
        end
        scfd_pkg::OP_TICK: begin
          if (tick_running) begin
            if (!q_status.empty) begin
              q_ctrl.pop      = upper_half;
              release_next    = upper_half && q_status.full;
              upper_half_next = !upper_half;
              if (!freeze0) begin
                if (nibble[1]) begin
                  direction_bits_next[0] = nibble[0];
                  enable_bits_n_next[0]  = 1'b0;
                  step0_next             = 1'b1;
                end else begin
                  enable_bits_n_next[0] = !nibble[0];
                end
              end
              if (!freeze1) begin
                if (nibble[3]) begin
                  direction_bits_next[1] = nibble[2];
                  enable_bits_n_next[1]  = 1'b0;
                  step1_next             = 1'b1;
                end else begin
                  enable_bits_n_next[1] = !nibble[2];
                end
              end
            end else begin
              underrun_next = 1'b1;
              if (halt_on_empty) begin
                tick_running_next = 1'b0;
              end
            end
          end
        end
        scfd_pkg::OP_RESTART: begin
          tick_running_next = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Free count as seen after this request, masked to the result width
  always_comb begin
    count_after = q_count;
    if (q_ctrl.push) begin
      count_after = q_count - CW'(1);
    end else if (q_ctrl.pop) begin
      count_after = q_count + CW'(1);
    end
    count_ext = {6'b0, count_after};
  end

  scfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (q_ctrl),
    .wr_byte (cmd.command_byte),
    .head    (q_head),
    .count   (q_count),
    .status  (q_status)
  );

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_half     <= 1'b0;
      direction_bits <= 2'b00;
      enable_bits_n  <= 2'b11;
      tick_running   <= 1'b1;
    end else begin
      upper_half     <= upper_half_next;
      direction_bits <= direction_bits_next;
      enable_bits_n  <= enable_bits_n_next;
      tick_running   <= tick_running_next;
    end
  end

  // Result valid: set on a request, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res.step0           <= step0_next;
      res.dir0            <= direction_bits_next[0];
      res.enable0_n       <= enable_bits_n_next[0];
      res.step1           <= step1_next;
      res.dir1            <= direction_bits_next[1];
      res.enable1_n       <= enable_bits_n_next[1];
      res.free_slots      <= count_ext[scfd_pkg::FREE_SLOTS_W-1:0];
      res.append_accepted <= accepted_next;
      res.write_release   <= release_next;
      res.underrun        <= underrun_next;
      res.running         <= tick_running_next;
    end
  end

  assign res.valid = res_valid;

endmodule

// ----- src/scfd_queue.sv -----
module scfd_queue #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  scfd_pkg::queue_ctrl_t      ctrl,
  input  logic [7:0]                 wr_byte,
  output logic [7:0]                 head,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output scfd_pkg::queue_status_t    status
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] read_slot;
  logic [AW-1:0] write_slot;
  logic [AW-1:0] read_slot_next;
  logic [AW-1:0] write_slot_next;
  logic [CW-1:0] count_next;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH-1)) ? '0 : p + AW'(1);
  endfunction

  // Advance pointers and free count
  always_comb begin
    read_slot_next  = ctrl.pop ? wrap_inc(read_slot) : read_slot;
    write_slot_next = ctrl.push ? wrap_inc(write_slot) : write_slot;
    count_next      = count;
    if (ctrl.push) begin
      count_next = count - CW'(1);
    end else if (ctrl.pop) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_slot  <= '0;
      write_slot <= '0;
      count      <= CW'(DEPTH);
    end else begin
      read_slot  <= read_slot_next;
      write_slot <= write_slot_next;
      count      <= count_next;
    end
  end

  // Store bytes and read ahead at the next head slot, bypassing a same-slot write
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[write_slot] <= wr_byte;
    end
    if (ctrl.push && (write_slot == read_slot_next)) begin
      head <= wr_byte;
    end else begin
      head <= mem[read_slot_next];
    end
  end

  assign status.full      = (count == '0);
  assign status.empty     = (count == CW'(DEPTH));
  assign status.last_slot = (count == CW'(1));

endmodule

// ----- dv/stepper_command_fifo_driver_unit_tb.sv -----
`timescale 1ns / 1ps

module stepper_command_fifo_driver_unit_tb;

  localparam int unsigned DEPTH = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [scfd_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 8'hFF;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 125;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] cmd_byte;
    logic       pin0;
    logic       pin1;
  } request_t;

  typedef struct packed {
    logic       step0;
    logic       dir0;
    logic       enable0_n;
    logic       step1;
    logic       dir1;
    logic       enable1_n;
    logic [5:0] free_slots;
    logic       append_accepted;
    logic       write_release;
    logic       underrun;
    logic       running;
  } motion_t;

  logic clk;
  logic rst;

  scfd_cmd_if cmd_if ();
  scfd_res_if res_if ();
  scfd_cfg_if cfg_if ();

  stepper_command_fifo_driver_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  // Shadow copy of the queue, motor pins and settings
  logic [7:0]  shadow_store [DEPTH];
  int unsigned shadow_rd = 0;
  int unsigned shadow_wr = 0;
  int unsigned shadow_free = DEPTH;
  logic        shadow_upper = 1'b0;
  logic [1:0]  shadow_dir = 2'b00;
  logic [1:0]  shadow_en_n = 2'b11;
  logic        shadow_running = 1'b1;
  logic        set_halt_on_empty = 1'b0;
  logic        set_limit_stop0 = 1'b0;
  logic        set_limit_stop1 = 1'b0;
  logic        set_invert0 = 1'b0;
  logic        set_invert1 = 1'b0;

  request_t pending_requests [$];
  motion_t  expected_motion [$];

  int unsigned mismatch_count = 0;
  int unsigned requests_seen = 0;
  int unsigned append_count = 0;
  int unsigned refused_appends = 0;
  int unsigned tick_count = 0;
  int unsigned underrun_ticks = 0;
  int unsigned stalled_ticks = 0;
  int unsigned restart_count = 0;
  int unsigned released_writes = 0;
  int unsigned step_pulses = 0;
  int unsigned settings_used = 0;

  logic        cmd_taken = 1'b0;
  logic        cmd_quiet = 1'b0;
  logic        res_quiet = 1'b0;
  int unsigned cmd_gap = 0;
  int unsigned res_stall = 0;
  request_t    next_req;
  motion_t     got_motion;
  motion_t     want_motion;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic request_t make_req(logic [1:0] op, logic [7:0] cmd_byte,
                                        logic pin0, logic pin1);
    request_t r;
    r.op = op;
    r.cmd_byte = cmd_byte;
    r.pin0 = pin0;
    r.pin1 = pin1;
    return r;
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic string fmt_motion(motion_t m);
    return $sformatf({"step %b/%b dir %b/%b en_n %b/%b free %0d acc %b rel %b ",
                      "und %b run %b"}, m.step0, m.step1, m.dir0, m.dir1,
                     m.enable0_n, m.enable1_n, m.free_slots, m.append_accepted,
                     m.write_release, m.underrun, m.running);
  endfunction

  // Apply one register write to the shadow settings
  function automatic void apply_register(logic [scfd_pkg::CFG_INDEX_W-1:0] idx,
                                         logic value);
    case (idx)
      scfd_pkg::REG_HALT_ON_EMPTY:      set_halt_on_empty = value;
      scfd_pkg::REG_LIMIT_STOP_AXIS0:   set_limit_stop0 = value;
      scfd_pkg::REG_LIMIT_STOP_AXIS1:   set_limit_stop1 = value;
      scfd_pkg::REG_LIMIT_INVERT_AXIS0: set_invert0 = value;
      scfd_pkg::REG_LIMIT_INVERT_AXIS1: set_invert1 = value;
      default: ;
    endcase
  endfunction

  // Advance the shadow queue by one request and return the motor pins and flags
  function automatic motion_t predict_motion(request_t r);
    motion_t    m;
    logic [3:0] nib;
    logic       lim0;
    logic       lim1;
    m = '0;
    requests_seen++;
    case (r.op)
      scfd_pkg::OP_APPEND: begin
        append_count++;
        if (shadow_free != 0) begin
          shadow_store[shadow_wr] = r.cmd_byte;
          shadow_wr = (shadow_wr + 1) % DEPTH;
          shadow_free--;
          m.append_accepted = (shadow_free != 0);
        end else begin
          refused_appends++;
        end
      end
      scfd_pkg::OP_TICK: begin
        tick_count++;
        if (!shadow_running) begin
          stalled_ticks++;
        end else if (shadow_free < DEPTH) begin
          nib = shadow_upper ? shadow_store[shadow_rd][7:4] : shadow_store[shadow_rd][3:0];
          lim0 = r.pin0 ^ set_invert0;
          lim1 = r.pin1 ^ set_invert1;
          // Second nibble of a byte frees its slot
          if (shadow_upper) begin
            m.write_release = (shadow_free == 0);
            shadow_rd = (shadow_rd + 1) % DEPTH;
            shadow_free++;
          end
          shadow_upper = ~shadow_upper;
          // Hold an axis while its limit is active and limit stop is on
          if (!(lim0 && set_limit_stop0)) begin
            if (nib[1]) begin
              shadow_dir[0] = nib[0];
              shadow_en_n[0] = 1'b0;
              m.step0 = 1'b1;
            end else begin
              shadow_en_n[0] = ~nib[0];
            end
          end
          if (!(lim1 && set_limit_stop1)) begin
            if (nib[3]) begin
              shadow_dir[1] = nib[2];
              shadow_en_n[1] = 1'b0;
              m.step1 = 1'b1;
            end else begin
              shadow_en_n[1] = ~nib[2];
            end
          end
        end else begin
          m.underrun = 1'b1;
          underrun_ticks++;
          if (set_halt_on_empty) shadow_running = 1'b0;
        end
      end
      scfd_pkg::OP_RESTART: begin
        restart_count++;
        shadow_running = 1'b1;
      end
      default: ;
    endcase
    m.dir0 = shadow_dir[0];
    m.enable0_n = shadow_en_n[0];
    m.dir1 = shadow_dir[1];
    m.enable1_n = shadow_en_n[1];
    m.free_slots = shadow_free[5:0];
    m.running = shadow_running;
    if (m.write_release) released_writes++;
    step_pulses += m.step0 + m.step1;
    return m;
  endfunction

  function automatic void report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
  endfunction

  // Request driver: advance on acceptance, idle between requests
  always @(negedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_taken) begin
      if (cmd_gap != 0) begin
        cmd_if.valid <= 1'b0;
        cmd_gap <= cmd_gap - 1;
      end else if (pending_requests.size() != 0) begin
        next_req = pending_requests.pop_front();
        cmd_if.op <= next_req.op;
        cmd_if.command_byte <= next_req.cmd_byte;
        cmd_if.limit_pin0 <= next_req.pin0;
        cmd_if.limit_pin1 <= next_req.pin1;
        cmd_if.valid <= 1'b1;
        if ($urandom_range(49) == 0) cmd_quiet <= ~cmd_quiet;
        cmd_gap <= cmd_quiet ? 0 : pick_gap();
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // Result side: stall at random, with quiet stretches
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (res_stall != 0) begin
      res_if.ready <= 1'b0;
      res_stall <= res_stall - 1;
    end else begin
      res_if.ready <= 1'b1;
      if ($urandom_range(49) == 0) res_quiet <= ~res_quiet;
      if (!res_quiet && $urandom_range(3) == 0) res_stall <= pick_gap();
    end
  end

  // Monitor: track settings, predict on each accepted request, check each result
  always @(posedge clk) begin
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_if.valid && cmd_if.ready;
      if (cfg_if.valid && cfg_if.ready) apply_register(cfg_if.index, cfg_if.wdata);
      if (cmd_if.valid && cmd_if.ready) begin
        expected_motion.push_back(predict_motion(make_req(cmd_if.op, cmd_if.command_byte,
                                                          cmd_if.limit_pin0,
                                                          cmd_if.limit_pin1)));
      end
      if (res_if.valid && res_if.ready) begin
        got_motion.step0 = res_if.step0;
        got_motion.dir0 = res_if.dir0;
        got_motion.enable0_n = res_if.enable0_n;
        got_motion.step1 = res_if.step1;
        got_motion.dir1 = res_if.dir1;
        got_motion.enable1_n = res_if.enable1_n;
        got_motion.free_slots = res_if.free_slots;
        got_motion.append_accepted = res_if.append_accepted;
        got_motion.write_release = res_if.write_release;
        got_motion.underrun = res_if.underrun;
        got_motion.running = res_if.running;
        if (expected_motion.size() == 0) begin
          report_mismatch({"result with no request pending: ", fmt_motion(got_motion)});
        end else begin
          want_motion = expected_motion.pop_front();
          if (got_motion !== want_motion) begin
            report_mismatch({"expected ", fmt_motion(want_motion), " got ",
                             fmt_motion(got_motion)});
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [scfd_pkg::CFG_INDEX_W-1:0] idx, input logic value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(input logic stall, input logic stop0, input logic stop1,
                            input logic inv0, input logic inv1);
    write_reg(scfd_pkg::REG_HALT_ON_EMPTY, stall);
    write_reg(scfd_pkg::REG_LIMIT_STOP_AXIS0, stop0);
    write_reg(scfd_pkg::REG_LIMIT_STOP_AXIS1, stop1);
    write_reg(scfd_pkg::REG_LIMIT_INVERT_AXIS0, inv0);
    write_reg(scfd_pkg::REG_LIMIT_INVERT_AXIS1, inv1);
    settings_used++;
  endtask

  // Hold until every request is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || cmd_if.valid || expected_motion.size() != 0);
  endtask

  // Queue a phase of random requests in runs, so the queue fills and drains
  task automatic add_random_phase(input int unsigned count);
    int unsigned left;
    int unsigned run_len;
    int unsigned kind;
    logic        hold_pins;
    logic        pin0;
    logic        pin1;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        run_len = $urandom_range(40, 1);
        for (int i = 0; i < run_len && left > 0; i++) begin
          pending_requests.push_back(make_req(scfd_pkg::OP_APPEND, rand_byte(),
                                              rand_bit(), rand_bit()));
          left--;
        end
      end else if (kind < 88) begin
        run_len = $urandom_range(70, 1);
        hold_pins = rand_bit();
        pin0 = rand_bit();
        pin1 = rand_bit();
        for (int i = 0; i < run_len && left > 0; i++) begin
          if (!hold_pins) begin
            pin0 = rand_bit();
            pin1 = rand_bit();
          end
          pending_requests.push_back(make_req(scfd_pkg::OP_TICK, rand_byte(), pin0, pin1));
          left--;
        end
      end else if (kind < 97) begin
        pending_requests.push_back(make_req(scfd_pkg::OP_RESTART, rand_byte(),
                                            rand_bit(), rand_bit()));
        left--;
      end else begin
        // Unused op code: ignored by the block, not counted toward the phase length
        pending_requests.push_back(make_req(OP_UNUSED, rand_byte(),
                                            rand_bit(), rand_bit()));
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned guard;
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.op = scfd_pkg::OP_APPEND;
    cmd_if.command_byte = 8'h00;
    cmd_if.limit_pin0 = 1'b0;
    cmd_if.limit_pin1 = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = scfd_pkg::REG_HALT_ON_EMPTY;
    cfg_if.wdata = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: underrun without stall, every motor code, odd ops
    pending_requests.push_back(make_req(scfd_pkg::OP_TICK, 8'h00, 1'b0, 1'b0));
    pending_requests.push_back(make_req(scfd_pkg::OP_APPEND, 8'hE4, 1'b0, 1'b0));
    pending_requests.push_back(make_req(scfd_pkg::OP_APPEND, 8'h1B, 1'b1, 1'b1));
    pending_requests.push_back(make_req(scfd_pkg::OP_APPEND, 8'h00, 1'b0, 1'b1));
    pending_requests.push_back(make_req(scfd_pkg::OP_APPEND, 8'hFF, 1'b1, 1'b0));
    pending_requests.push_back(make_req(OP_UNUSED, 8'hFF, 1'b1, 1'b1));
    pending_requests.push_back(make_req(scfd_pkg::OP_RESTART, 8'h00, 1'b0, 1'b0));
    for (int i = 0; i < 8; i++) begin
      pending_requests.push_back(make_req(scfd_pkg::OP_TICK, 8'hFF, i[0], i[1]));
    end
    pending_requests.push_back(make_req(scfd_pkg::OP_TICK, 8'h00, 1'b1, 1'b1));
    wait_drained();

    // Stall on empty, limit freeze, ignored register index
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    write_reg(REG_UNUSED, 1'b0);
    pending_requests.push_back(make_req(scfd_pkg::OP_APPEND, 8'hFF, 1'b0, 1'b0));
    pending_requests.push_back(make_req(scfd_pkg::OP_TICK, 8'h00, 1'b0, 1'b1));
    pending_requests.push_back(make_req(scfd_pkg::OP_TICK, 8'h00, 1'b1, 1'b0));
    pending_requests.push_back(make_req(scfd_pkg::OP_TICK, 8'h00, 1'b1, 1'b0));
    pending_requests.push_back(make_req(scfd_pkg::OP_TICK, 8'h00, 1'b0, 1'b0));
    pending_requests.push_back(make_req(scfd_pkg::OP_RESTART, 8'h00, 1'b0, 1'b0));
    pending_requests.push_back(make_req(scfd_pkg::OP_TICK, 8'h00, 1'b0, 1'b0));
    pending_requests.push_back(make_req(scfd_pkg::OP_RESTART, 8'hFF, 1'b1, 1'b1));
    wait_drained();

    // Random phases: all off, all on, then random settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) set_config(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      else if (p == 1) set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      else set_config(rand_bit(), rand_bit(), rand_bit(), rand_bit(), rand_bit());
      add_random_phase(ITEMS_PER_PHASE);
      wait_drained();
    end

    guard = 0;
    while (expected_motion.size() != 0 && guard < 1000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (expected_motion.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_motion.size()));
    end

    $display("Covered %0d requests over %0d settings: %0d appends (%0d refused), %0d restarts",
             requests_seen, settings_used, append_count, refused_appends, restart_count);
    $display("Ticks %0d: %0d underruns, %0d ignored while stalled, %0d releases, %0d steps",
             tick_count, underrun_ticks, stalled_ticks, released_writes, step_pulses);
    if (mismatch_count == 0) begin
      $display("stepper_command_fifo_driver_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("stepper_command_fifo_driver_unit verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Timeout with %0d requests and %0d results outstanding",
             pending_requests.size(), expected_motion.size());
    $display("stepper_command_fifo_driver_unit verification failed");
    $finish;
  end

endmodule
